// ===== sv/gtg_pkg.sv =====
// Shared types and constants for the go-to-goal drive controller.
// Holds field widths, register indexes and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package gtg_pkg;

    localparam int POS_W    = 15;
    localparam int HD_W     = 14;
    localparam int DIFF_W   = 16;
    localparam int SQ_W     = 32;
    localparam int RAD_W    = 40;
    localparam int ROOT_W   = 20;
    localparam int XY_W     = 35;
    localparam int Z_W      = 34;
    localparam int ERR_W    = 35;
    localparam int MB_W     = 17;
    localparam int PROD_W   = ERR_W + MB_W;
    localparam int GAIN_W   = 8;
    localparam int LIN_W    = 16;
    localparam int ANG_W    = 17;
    localparam int CFG_IDX_W = 3;
    localparam int ATAN_LEN = 24;
    localparam int ATAN_IDX_W = 5;
    localparam int ATAN_W   = 30;

    localparam logic signed [Z_W-1:0] PI_OVER_2_Q30 = 34'sd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GOAL_X       = 3'd0,
        CFG_GOAL_Y       = 3'd1,
        CFG_ARRIVE_TOL   = 3'd2,
        CFG_LINEAR_GAIN  = 3'd3,
        CFG_ANGULAR_GAIN = 3'd4
    } cfg_idx_t;

    // round(atan(2^-i) * 2^30)
    function automatic logic [ATAN_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048576;
            5'd11:   v = 30'd524288;
            5'd12:   v = 30'd262144;
            5'd13:   v = 30'd131072;
            5'd14:   v = 30'd65536;
            5'd15:   v = 30'd32768;
            5'd16:   v = 30'd16384;
            5'd17:   v = 30'd8192;
            5'd18:   v = 30'd4096;
            5'd19:   v = 30'd2048;
            5'd20:   v = 30'd1024;
            5'd21:   v = 30'd512;
            5'd22:   v = 30'd256;
            5'd23:   v = 30'd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/gtg_sqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
// Depends on gtg_pkg.
`default_nettype none

module gtg_sqrt
    import gtg_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [RAD_W-1:0]  radicand,
    output logic      [ROOT_W-1:0] root,
    output logic                   done
);

    typedef enum logic {SQ_IDLE, SQ_RUN} sq_state_t;

    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W);

    sq_state_t          state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [RAD_W-1:0]   rad_reg, rad_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic               done_reg, done_next;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        done_next  = done_reg;
        case (state_reg)
            SQ_IDLE: begin
                if (start) begin
                    rad_next   = radicand;
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    done_next  = 1'b0;
                    state_next = SQ_RUN;
                end
            end
            SQ_RUN: begin
                rad_next = {rad_reg[RAD_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_W - 1)) begin
                    done_next  = 1'b1;
                    state_next = SQ_IDLE;
                end
            end
            default: state_next = SQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SQ_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== sv/gtg_cordic.sv =====
// CORDIC vectoring unit: atan2 of the goal offset in Q.30 radians,
// one micro-rotation per cycle. Depends on gtg_pkg.
`default_nettype none

module gtg_cordic
    import gtg_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic signed [DIFF_W-1:0] dx,
    input  wire logic signed [DIFF_W-1:0] dy,
    output logic signed      [Z_W-1:0]    bearing,
    output logic                          done
);

    typedef enum logic {CD_IDLE, CD_RUN} cd_state_t;

    cd_state_t               state_reg, state_next;
    logic [ATAN_IDX_W-1:0]   cnt_reg, cnt_next;
    logic signed [XY_W-1:0]  x_reg, x_next;
    logic signed [XY_W-1:0]  y_reg, y_next;
    logic signed [Z_W-1:0]   z_reg, z_next;
    logic                    done_reg, done_next;
    logic signed [XY_W-1:0]  x_in, y_in, xs, ys;
    logic signed [Z_W-1:0]   step_angle;

    assign x_in = {{3{dx[DIFF_W-1]}}, dx, 16'b0};
    assign y_in = {{3{dy[DIFF_W-1]}}, dy, 16'b0};
    assign xs   = x_reg >>> cnt_reg;
    assign ys   = y_reg >>> cnt_reg;
    assign step_angle = {{(Z_W-ATAN_W){1'b0}}, atan_q30(cnt_reg)};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        done_next  = done_reg;
        case (state_reg)
            CD_IDLE: begin
                if (start) begin
                    // left half-plane: rotate by a quarter turn first
                    if (dx[DIFF_W-1]) begin
                        if (!dy[DIFF_W-1]) begin
                            x_next = y_in;
                            y_next = -x_in;
                            z_next = PI_OVER_2_Q30;
                        end else begin
                            x_next = -y_in;
                            y_next = x_in;
                            z_next = -PI_OVER_2_Q30;
                        end
                    end else begin
                        x_next = x_in;
                        y_next = y_in;
                        z_next = '0;
                    end
                    cnt_next   = '0;
                    done_next  = 1'b0;
                    state_next = CD_RUN;
                end
            end
            CD_RUN: begin
                if (!y_reg[XY_W-1]) begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + step_angle;
                end else begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - step_angle;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ATAN_IDX_W'(STEPS - 1)) begin
                    done_next  = 1'b1;
                    state_next = CD_IDLE;
                end
            end
            default: state_next = CD_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CD_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign bearing = z_reg;
    assign done    = done_reg;

endmodule

`default_nettype wire

// ===== sv/go_to_goal_drive_controller.sv =====
// Go-to-goal proportional drive controller: sequencer, shared multiplier,
// configuration registers and result register. Depends on gtg_pkg,
// gtg_sqrt and gtg_cordic.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------
//   s_      | in        | s_tvalid / s_tready  | s_tdata: pos_x, pos_y, heading
//   m_      | out       | m_tvalid / m_tready  | m_tdata: linear_drive, angular_drive
//           |           |                      | m_tuser: arrived
//   cfg_    | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// When the goal is reached, one pose runs through the square, tolerance and check
// states straight to the result; otherwise it waits until the 20-step bit-serial square
// root and the CORDIC_STEPS-step CORDIC pass, which run alongside, are both done.
// s_tready is high only while the sequencer is idle; a finished result waits
// in the output register, so the next pose can be taken while m_ stalls.
// Synchronous active-low reset clears the sequencer and arrival flag and presets config.
`default_nettype none

module go_to_goal_drive_controller
    import gtg_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [47:0]          s_tdata,   // pos_x[14:0], pos_y[29:15], heading[43:30]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [39:0]               m_tdata,   // linear_drive[15:0], angular_drive[32:16]
    output logic                      m_tuser,   // arrived[0]
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQX, ST_SQY, ST_TOL, ST_CHK, ST_RUN,
        ST_ANG, ST_LIN, ST_FIN, ST_DONE
    } state_t;

    state_t                      state_reg, state_next;
    logic [POS_W-1:0]            goal_x_reg, goal_y_reg, tol_reg;
    logic [GAIN_W-1:0]           lin_gain_reg, ang_gain_reg;
    logic                        reached_reg, reached_next;
    logic signed [DIFF_W-1:0]    dx_reg, dx_next, dy_reg, dy_next;
    logic signed [HD_W-1:0]      hd_reg, hd_next;
    logic [SQ_W-1:0]             sq_reg, sq_next;
    logic signed [ERR_W-1:0]     err_reg, err_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic [LIN_W-1:0]            lin_reg, lin_next;
    logic [ANG_W-1:0]            ang_reg, ang_next;
    logic                        arr_reg, arr_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [39:0]                 m_tdata_reg, m_tdata_next;
    logic                        m_tuser_reg, m_tuser_next;

    logic signed [ERR_W-1:0]     mul_a;
    logic signed [MB_W-1:0]      mul_b;
    logic                        unit_start;
    logic [ROOT_W-1:0]           root;
    logic                        sqrt_done;
    logic signed [Z_W-1:0]       bearing;
    logic                        cordic_done;
    logic [POS_W-1:0]            in_x, in_y;
    logic signed [HD_W-1:0]      in_hd;
    logic signed [PROD_W-1:0]    ang_sum;
    logic signed [PROD_W-24:0]   ang_full;
    logic [PROD_W-1:0]           lin_sum;
    logic [PROD_W-9:0]           lin_full;

    assign in_x  = s_tdata[14:0];
    assign in_y  = s_tdata[29:15];
    assign in_hd = s_tdata[43:30];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    gtg_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (unit_start),
        .radicand ({sq_reg, 8'b0}),
        .root     (root),
        .done     (sqrt_done)
    );

    gtg_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (unit_start),
        .dx       (dx_reg),
        .dy       (dy_reg),
        .bearing  (bearing),
        .done     (cordic_done)
    );

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQX: begin
                mul_a = {{(ERR_W-DIFF_W){dx_reg[DIFF_W-1]}}, dx_reg};
                mul_b = {dx_reg[DIFF_W-1], dx_reg};
            end
            ST_SQY: begin
                mul_a = {{(ERR_W-DIFF_W){dy_reg[DIFF_W-1]}}, dy_reg};
                mul_b = {dy_reg[DIFF_W-1], dy_reg};
            end
            ST_TOL: begin
                mul_a = {{(ERR_W-POS_W){1'b0}}, tol_reg};
                mul_b = {{(MB_W-POS_W){1'b0}}, tol_reg};
            end
            ST_ANG: begin
                mul_a = err_reg;
                mul_b = {{(MB_W-GAIN_W){1'b0}}, ang_gain_reg};
            end
            ST_LIN: begin
                mul_a = {{(ERR_W-ROOT_W){1'b0}}, root};
                mul_b = {{(MB_W-GAIN_W){1'b0}}, lin_gain_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign ang_sum  = prod_reg + PROD_W'(64'sd4194304);
    assign ang_full = ang_sum[PROD_W-1:23];
    assign lin_sum  = prod_reg + PROD_W'(128);
    assign lin_full = lin_sum[PROD_W-1:8];

    assign unit_start = (state_reg == ST_CHK) &&
                        !(reached_reg || (sq_reg <= prod_reg[SQ_W-1:0]));

    always_comb begin
        state_next    = state_reg;
        reached_next  = reached_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        hd_next       = hd_reg;
        sq_next       = sq_reg;
        err_next      = err_reg;
        prod_next     = mul_a * mul_b;
        lin_next      = lin_reg;
        ang_next      = ang_reg;
        arr_next      = arr_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    dx_next    = $signed({1'b0, goal_x_reg}) - $signed({1'b0, in_x});
                    dy_next    = $signed({1'b0, goal_y_reg}) - $signed({1'b0, in_y});
                    hd_next    = in_hd;
                    state_next = ST_SQX;
                end
            end
            ST_SQX: state_next = ST_SQY;
            ST_SQY: begin
                sq_next    = prod_reg[SQ_W-1:0];
                state_next = ST_TOL;
            end
            ST_TOL: begin
                sq_next    = sq_reg + prod_reg[SQ_W-1:0];
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (!unit_start) begin
                    reached_next = 1'b1;
                    lin_next     = '0;
                    ang_next     = '0;
                    arr_next     = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (sqrt_done && cordic_done) begin
                    err_next = {bearing[Z_W-1], bearing} -
                               {{2{hd_reg[HD_W-1]}}, hd_reg, 19'b0};
                    state_next = ST_ANG;
                end
            end
            ST_ANG: state_next = ST_LIN;
            ST_LIN: begin
                if (ang_full > $signed((PROD_W-23)'(65535))) begin
                    ang_next = 17'h0FFFF;
                end else if (ang_full < -$signed((PROD_W-23)'(65536))) begin
                    ang_next = 17'h10000;
                end else begin
                    ang_next = ang_full[ANG_W-1:0];
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (|lin_full[PROD_W-9:LIN_W]) begin
                    lin_next = '1;
                end else begin
                    lin_next = lin_full[LIN_W-1:0];
                end
                arr_next   = 1'b0;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0, ang_reg, lin_reg};
                    m_tuser_next  = arr_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            reached_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            reached_reg  <= reached_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        hd_reg      <= hd_next;
        sq_reg      <= sq_next;
        err_reg     <= err_next;
        prod_reg    <= prod_next;
        lin_reg     <= lin_next;
        ang_reg     <= ang_next;
        arr_reg     <= arr_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_x_reg   <= POS_W'(2048);
            goal_y_reg   <= POS_W'(2048);
            tol_reg      <= POS_W'(20);
            lin_gain_reg <= GAIN_W'(16);
            ang_gain_reg <= GAIN_W'(64);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_GOAL_X:       goal_x_reg   <= cfg_data[POS_W-1:0];
                CFG_GOAL_Y:       goal_y_reg   <= cfg_data[POS_W-1:0];
                CFG_ARRIVE_TOL:   tol_reg      <= cfg_data[POS_W-1:0];
                CFG_LINEAR_GAIN:  lin_gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_ANGULAR_GAIN: ang_gain_reg <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire
